>>> sv/tgsf_pkg.sv
// shared types, codes and sizing constants for the timestamp gated synapse fifo
package tgsf_pkg;

   // default number of entries the synapse store holds
   localparam int QUEUE_DEPTH_DEF = 64;

   // entries of the command queue between front and back
   localparam int CMDQ_DEPTH = 2;

   // field widths
   localparam int WEIGHT_W = 32;
   localparam int INDEX_W = 16;
   localparam int ENTRY_W = WEIGHT_W + INDEX_W;
   localparam int LEVEL_W = 8;
   localparam int LIMIT_W = 9;
   localparam int ERR_W = 2;

   // queue limit after reset
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd64;

   // error codes
   localparam logic [ERR_W-1:0] ERR_NONE = 2'd0;
   localparam logic [ERR_W-1:0] ERR_ORDER = 2'd1;
   localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd2;
   localparam logic [ERR_W-1:0] ERR_HALF = 2'd3;

   // what the back end releases for one request
   localparam logic [1:0] ACC_NONE = 2'd0;
   localparam logic [1:0] ACC_DIRECT = 2'd1;
   localparam logic [1:0] ACC_POP = 2'd2;

   // command handed from front to back
   typedef struct packed {
      logic [1:0]          kind;
      logic [WEIGHT_W-1:0] weight;
      logic [INDEX_W-1:0]  index;
      logic                empty_changed;
      logic                empty_now;
      logic [ERR_W-1:0]    error_code;
   } tgsf_cmd_type;

endpackage

>>> sv/tgsf_ram.sv
// generic single write, single read ram with registered read data
module tgsf_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/tgsf_cmdq.sv
// short register queue carrying commands from front to back
module tgsf_cmdq
   import tgsf_pkg::*;
#(
   parameter int WIDTH = 60
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             not_empty,
   output logic             full
);

   localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
   localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CMDQ_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CMDQ_DEPTH);

   logic [WIDTH-1:0] slot_ff [CMDQ_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign not_empty = (count_ff != '0);
   assign full = (count_ff == CNT_FULL);
   assign head_data = slot_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> sv/tgsf_front.sv
// front end: accepts requests, checks parity order, half pairs and overflow, runs the store control
module tgsf_front
   import tgsf_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int PTR_W = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_syn_valid,
   input  logic                req_syn_ts_valid,
   input  logic [WEIGHT_W-1:0] req_weight,
   input  logic [INDEX_W-1:0]  req_index,
   input  logic                req_syn_parity,
   input  logic                req_core_valid,
   input  logic                req_core_parity,
   input  logic [LEVEL_W-1:0]  req_out_queue_level,
   input  logic                csr_wr_en,
   input  logic [LIMIT_W-1:0]  csr_wr_data,
   input  logic                cmdq_full,
   output logic                cmd_push,
   output tgsf_cmd_type        cmd,
   output logic [PTR_W-1:0]    cmd_addr,
   output logic                ram_wr_en,
   output logic [PTR_W-1:0]    ram_wr_addr,
   output logic [ENTRY_W-1:0]  ram_wr_data
);

   // physical store keeps spare slots so a pending read is never overwritten
   localparam int PHYS_DEPTH = QUEUE_DEPTH + CMDQ_DEPTH;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(PHYS_DEPTH - 1);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
   localparam int SUM_W = ((CNT_W > LIMIT_W) ? CNT_W : LIMIT_W) + 1;

   logic [LIMIT_W-1:0] limit_ff;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               last_par_ff, last_par_in;
   logic               core_par_ff, core_par_in;
   logic               empty_ff, empty_in;

   logic               accept;
   logic               full_pair;
   logic               push;
   logic               pop;
   logic               direct;
   logic               changed;
   logic [ERR_W-1:0]   err;
   logic [SUM_W-1:0]   level_sum;
   logic [CNT_W-1:0]   count_after_push;

   assign req_stall = cmdq_full;
   assign accept = req_valid && !cmdq_full;
   assign full_pair = req_syn_valid && req_syn_ts_valid;
   assign level_sum = SUM_W'(count_ff) + SUM_W'(req_out_queue_level);

   // classify the request
   always_comb begin
      err = ERR_NONE;
      last_par_in = last_par_ff;
      push = 1'b0;
      direct = 1'b0;
      if (full_pair) begin
         if (last_par_ff != core_par_ff && req_syn_parity == core_par_ff) begin
            err = ERR_ORDER;
         end else begin
            last_par_in = req_syn_parity;
            if (req_syn_parity == core_par_ff) begin
               if (count_ff == '0) begin
                  direct = 1'b1;
               end else if (count_ff >= CNT_FULL) begin
                  err = ERR_OVERFLOW;
               end else begin
                  push = 1'b1;
               end
            end else if (level_sum >= SUM_W'(limit_ff) || count_ff >= CNT_FULL) begin
               err = ERR_OVERFLOW;
            end else begin
               push = 1'b1;
            end
         end
      end else if (req_syn_valid || req_syn_ts_valid) begin
         err = ERR_HALF;
      end
   end

   // core parity, release and downstream empty tracking
   always_comb begin
      core_par_in = core_par_ff;
      empty_in = empty_ff;
      changed = 1'b0;
      pop = 1'b0;
      count_after_push = count_ff + CNT_W'(push);
      if (err == ERR_NONE) begin
         if (req_core_valid) begin
            core_par_in = req_core_parity;
         end
         pop = (core_par_in == last_par_in) && (count_after_push != '0);
         if (!empty_ff && req_out_queue_level == '0) begin
            empty_in = 1'b1;
            changed = 1'b1;
         end else if (empty_ff && req_out_queue_level != '0) begin
            empty_in = 1'b0;
            changed = 1'b1;
         end
      end
      count_in = count_after_push - CNT_W'(pop);
      wr_ptr_in = push ? ((wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? ((rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1) : rd_ptr_ff;
   end

   // command for the back end
   always_comb begin
      cmd.kind = ACC_NONE;
      cmd.weight = '0;
      cmd.index = '0;
      if (pop) begin
         cmd.kind = ACC_POP;
      end else if (direct) begin
         cmd.kind = ACC_DIRECT;
         cmd.weight = req_weight;
         cmd.index = req_index;
      end
      cmd.empty_changed = changed;
      cmd.empty_now = empty_in;
      cmd.error_code = err;
   end

   assign cmd_push = accept;
   assign cmd_addr = rd_ptr_ff;
   assign ram_wr_en = accept && push;
   assign ram_wr_addr = wr_ptr_ff;
   assign ram_wr_data = {req_weight, req_index};

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff <= '0;
         last_par_ff <= 1'b0;
         core_par_ff <= 1'b0;
         empty_ff <= 1'b1;
      end else if (accept) begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff <= count_in;
         last_par_ff <= last_par_in;
         core_par_ff <= core_par_in;
         empty_ff <= empty_in;
      end
   end

   // queue limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

endmodule

>>> sv/tgsf_back.sv
// back end: reads released entries from the store and drives the response register
module tgsf_back
   import tgsf_pkg::*;
#(
   parameter int PTR_W = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_ready,
   input  tgsf_cmd_type        cmd,
   input  logic [PTR_W-1:0]    cmd_addr,
   output logic                cmd_pop,
   output logic                ram_rd_en,
   output logic [PTR_W-1:0]    ram_rd_addr,
   input  logic [ENTRY_W-1:0]  ram_rd_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_acc_valid,
   output logic [WEIGHT_W-1:0] rsp_acc_weight,
   output logic [INDEX_W-1:0]  rsp_acc_index,
   output logic                rsp_empty_changed,
   output logic                rsp_empty_now,
   output logic [ERR_W-1:0]    rsp_error_code
);

   logic         out_valid_ff, out_valid_in;
   tgsf_cmd_type out_cmd_ff;
   logic         advance;

   // output stage moves when empty or when the response is taken
   assign advance = !out_valid_ff || !rsp_stall;
   assign cmd_pop = advance && cmd_ready;
   assign out_valid_in = cmd_ready ? 1'b1 : (out_valid_ff && rsp_stall);

   // store read lines up with the output stage
   assign ram_rd_en = cmd_pop;
   assign ram_rd_addr = cmd_addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         out_cmd_ff <= cmd;
      end
   end

   // response fields, popped entries come from the store read data
   assign rsp_valid = out_valid_ff;
   assign rsp_acc_valid = (out_cmd_ff.kind != ACC_NONE);
   assign rsp_acc_weight = (out_cmd_ff.kind == ACC_POP) ?
                           ram_rd_data[ENTRY_W-1:INDEX_W] : out_cmd_ff.weight;
   assign rsp_acc_index = (out_cmd_ff.kind == ACC_POP) ?
                          ram_rd_data[INDEX_W-1:0] : out_cmd_ff.index;
   assign rsp_empty_changed = out_cmd_ff.empty_changed;
   assign rsp_empty_now = out_cmd_ff.empty_now;
   assign rsp_error_code = out_cmd_ff.error_code;

endmodule

>>> sv/timestamp_gated_synapse_fifo.sv
// top level of the timestamp gated synapse fifo
//
// Request channel (req_*): one step per request: an optional synapse entry with its
// timestamp parity, an optional core parity update and the downstream queue level.
// Response channel (rsp_*): exactly one response per request, in order, carrying the
// released entry (if any), the downstream empty status change and an error code.
// csr_wr_en / csr_wr_data write the queue limit; write it only while the block is idle.
// The front end decides every request combinationally against the store control
// state and pushes a command into a two entry queue; the back end reads released
// entries from the store ram and holds the response in its output register.
// Throughput is one request per cycle while req_stall is low; the store ram has one write
// and one read port and the front end handles one request a cycle. An accepted request
// passes through the command queue and the output register before it can be taken as a response.
// Reset clears pointers, counts and parities, marks the downstream side empty and
// sets the queue limit to 64; store contents are not cleared and need no pass.
// When rsp_stall is held the response stays put, the command queue fills and after
// two further requests req_stall rises until the response side moves again.
module timestamp_gated_synapse_fifo
   import tgsf_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_syn_valid,
   input  logic                req_syn_ts_valid,
   input  logic [WEIGHT_W-1:0] req_weight,
   input  logic [INDEX_W-1:0]  req_index,
   input  logic                req_syn_parity,
   input  logic                req_core_valid,
   input  logic                req_core_parity,
   input  logic [LEVEL_W-1:0]  req_out_queue_level,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_acc_valid,
   output logic [WEIGHT_W-1:0] rsp_acc_weight,
   output logic [INDEX_W-1:0]  rsp_acc_index,
   output logic                rsp_empty_changed,
   output logic                rsp_empty_now,
   output logic [ERR_W-1:0]    rsp_error_code,
   input  logic                csr_wr_en,
   input  logic [LIMIT_W-1:0]  csr_wr_data
);

   localparam int PHYS_DEPTH = QUEUE_DEPTH + CMDQ_DEPTH;
   localparam int PTR_W = $clog2(PHYS_DEPTH);
   localparam int CMD_W = $bits(tgsf_cmd_type) + PTR_W;

   logic               cmdq_full;
   logic               cmdq_not_empty;
   logic               cmd_push;
   logic               cmd_pop;
   tgsf_cmd_type       front_cmd;
   tgsf_cmd_type       back_cmd;
   logic [PTR_W-1:0]   front_addr;
   logic [PTR_W-1:0]   back_addr;
   logic [CMD_W-1:0]   cmdq_head;
   logic               ram_wr_en;
   logic [PTR_W-1:0]   ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data;
   logic               ram_rd_en;
   logic [PTR_W-1:0]   ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;

   // request classification and store control
   tgsf_front #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .PTR_W(PTR_W)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_syn_valid(req_syn_valid),
      .req_syn_ts_valid(req_syn_ts_valid),
      .req_weight(req_weight),
      .req_index(req_index),
      .req_syn_parity(req_syn_parity),
      .req_core_valid(req_core_valid),
      .req_core_parity(req_core_parity),
      .req_out_queue_level(req_out_queue_level),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .cmdq_full(cmdq_full),
      .cmd_push(cmd_push),
      .cmd(front_cmd),
      .cmd_addr(front_addr),
      .ram_wr_en(ram_wr_en),
      .ram_wr_addr(ram_wr_addr),
      .ram_wr_data(ram_wr_data)
   );

   // command queue between front and back
   tgsf_cmdq #(
      .WIDTH(CMD_W)
   ) u_cmdq (
      .clock(clock),
      .reset(reset),
      .push(cmd_push),
      .push_data({front_addr, front_cmd}),
      .pop(cmd_pop),
      .head_data(cmdq_head),
      .not_empty(cmdq_not_empty),
      .full(cmdq_full)
   );

   assign back_cmd = cmdq_head[$bits(tgsf_cmd_type)-1:0];
   assign back_addr = cmdq_head[CMD_W-1:$bits(tgsf_cmd_type)];

   // synapse entry store
   tgsf_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(PHYS_DEPTH)
   ) u_store (
      .clock(clock),
      .wr_en(ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en(ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // release and response stage
   tgsf_back #(
      .PTR_W(PTR_W)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .cmd_ready(cmdq_not_empty),
      .cmd(back_cmd),
      .cmd_addr(back_addr),
      .cmd_pop(cmd_pop),
      .ram_rd_en(ram_rd_en),
      .ram_rd_addr(ram_rd_addr),
      .ram_rd_data(ram_rd_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_acc_valid(rsp_acc_valid),
      .rsp_acc_weight(rsp_acc_weight),
      .rsp_acc_index(rsp_acc_index),
      .rsp_empty_changed(rsp_empty_changed),
      .rsp_empty_now(rsp_empty_now),
      .rsp_error_code(rsp_error_code)
   );

endmodule

>>> tb/tb_timestamp_gated_synapse_fifo.sv
`timescale 1ns / 1ps
// self-checking testbench for the timestamp gated synapse fifo, with a shadow model of the store
module tb_timestamp_gated_synapse_fifo;
   import tgsf_pkg::*;

   localparam int DEPTH = QUEUE_DEPTH_DEF;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 200;
   localparam int EXP_PTR_W = 4;
   localparam int EXP_SLOTS = 1 << EXP_PTR_W;

   // one request: optional synapse entry, optional core parity, downstream level
   typedef struct packed {
      logic                syn_valid;
      logic                syn_ts_valid;
      logic [WEIGHT_W-1:0] weight;
      logic [INDEX_W-1:0]  index;
      logic                syn_parity;
      logic                core_valid;
      logic                core_parity;
      logic [LEVEL_W-1:0]  level;
   } syn_step_type;

   // one response toward the accumulator
   typedef struct packed {
      logic                acc_valid;
      logic [WEIGHT_W-1:0] acc_weight;
      logic [INDEX_W-1:0]  acc_index;
      logic                empty_changed;
      logic                empty_now;
      logic [ERR_W-1:0]    error_code;
   } acc_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_syn_valid = 1'b0;
   logic                req_syn_ts_valid = 1'b0;
   logic [WEIGHT_W-1:0] req_weight = '0;
   logic [INDEX_W-1:0]  req_index = '0;
   logic                req_syn_parity = 1'b0;
   logic                req_core_valid = 1'b0;
   logic                req_core_parity = 1'b0;
   logic [LEVEL_W-1:0]  req_out_queue_level = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_acc_valid;
   logic [WEIGHT_W-1:0] rsp_acc_weight;
   logic [INDEX_W-1:0]  rsp_acc_index;
   logic                rsp_empty_changed;
   logic                rsp_empty_now;
   logic [ERR_W-1:0]    rsp_error_code;
   logic                csr_wr_en = 1'b0;
   logic [LIMIT_W-1:0]  csr_wr_data = '0;

   // shadow state of the synapse store and parities
   logic [ENTRY_W-1:0]  syn_store [DEPTH];
   logic [PTR_W-1:0]    rd_ptr = '0;
   logic [PTR_W-1:0]    wr_ptr = '0;
   int                  held_count = 0;
   logic                last_parity = 1'b0;
   logic                core_parity_q = 1'b0;
   logic                down_empty = 1'b1;
   logic [LIMIT_W-1:0]  queue_limit = LIMIT_RESET;

   // ring of expected responses, oldest at exp_rd_ptr
   acc_result_type      expected_ring [EXP_SLOTS];
   logic [EXP_PTR_W-1:0] exp_rd_ptr = '0;
   logic [EXP_PTR_W-1:0] exp_wr_ptr = '0;
   int                  exp_count = 0;
   int                  fail_count = 0;
   int                  quiet_cycles = 0;
   int                  send_idle_pct = 0;
   int                  rsp_stall_pct = 0;
   int                  hold_len = 0;
   int                  hold_left = 0;

   timestamp_gated_synapse_fifo dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_syn_valid       (req_syn_valid),
      .req_syn_ts_valid    (req_syn_ts_valid),
      .req_weight          (req_weight),
      .req_index           (req_index),
      .req_syn_parity      (req_syn_parity),
      .req_core_valid      (req_core_valid),
      .req_core_parity     (req_core_parity),
      .req_out_queue_level (req_out_queue_level),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_acc_valid       (rsp_acc_valid),
      .rsp_acc_weight      (rsp_acc_weight),
      .rsp_acc_index       (rsp_acc_index),
      .rsp_empty_changed   (rsp_empty_changed),
      .rsp_empty_now       (rsp_empty_now),
      .rsp_error_code      (rsp_error_code),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // advance the shadow store by one request and return the response it causes
   function automatic acc_result_type predict_release(input syn_step_type s);
      acc_result_type     r;
      logic [ENTRY_W-1:0] e;
      r = '0;
      r.empty_now = down_empty;
      if (s.syn_valid && s.syn_ts_valid) begin
         // entry matching the core while older mismatched entries wait
         if (last_parity != core_parity_q && s.syn_parity == core_parity_q) begin
            r.error_code = ERR_ORDER;
            return r;
         end
         last_parity = s.syn_parity;
         if (s.syn_parity == core_parity_q && held_count == 0) begin
            r.acc_valid = 1'b1;
            r.acc_weight = s.weight;
            r.acc_index = s.index;
         end else if (held_count >= DEPTH || (s.syn_parity != core_parity_q &&
                      held_count + int'(s.level) >= int'(queue_limit))) begin
            r.error_code = ERR_OVERFLOW;
            return r;
         end else begin
            syn_store[wr_ptr] = {s.weight, s.index};
            wr_ptr = wr_ptr + 1'b1;
            held_count++;
         end
      end else if (s.syn_valid || s.syn_ts_valid) begin
         r.error_code = ERR_HALF;
         return r;
      end
      if (s.core_valid)
         core_parity_q = s.core_parity;
      // release the oldest held entry while parities agree
      if (core_parity_q == last_parity && held_count > 0) begin
         e = syn_store[rd_ptr];
         rd_ptr = rd_ptr + 1'b1;
         held_count--;
         r.acc_valid = 1'b1;
         r.acc_weight = e[ENTRY_W-1:INDEX_W];
         r.acc_index = e[INDEX_W-1:0];
      end
      // downstream empty tracking
      if (down_empty != (s.level == 0)) begin
         down_empty = (s.level == 0);
         r.empty_changed = 1'b1;
      end
      r.empty_now = down_empty;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   // predict on each accepted request, compare each accepted response
   always @(posedge clock) begin : monitor
      syn_step_type   seen;
      acc_result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (exp_count == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               want = expected_ring[exp_rd_ptr];
               exp_rd_ptr = exp_rd_ptr + 1'b1;
               exp_count--;
               check_field("acc_valid", 32'(want.acc_valid), 32'(rsp_acc_valid));
               check_field("acc_weight", want.acc_weight, rsp_acc_weight);
               check_field("acc_index", 32'(want.acc_index), 32'(rsp_acc_index));
               check_field("empty_changed", 32'(want.empty_changed),
                           32'(rsp_empty_changed));
               check_field("empty_now", 32'(want.empty_now), 32'(rsp_empty_now));
               check_field("error_code", 32'(want.error_code), 32'(rsp_error_code));
            end
         end
         if (req_valid && !req_stall) begin
            seen = {req_syn_valid, req_syn_ts_valid, req_weight, req_index, req_syn_parity,
                    req_core_valid, req_core_parity, req_out_queue_level};
            expected_ring[exp_wr_ptr] = predict_release(seen);
            exp_wr_ptr = exp_wr_ptr + 1'b1;
            exp_count++;
         end
      end
   end

   // response stall: random, or a long hold-off counted here
   always @(negedge clock) begin
      if (hold_len > 0) begin
         hold_left = hold_len;
         hold_len = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // offer one request at the falling edge and hold it until taken
   task automatic send_step(input syn_step_type s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_syn_valid <= s.syn_valid;
      req_syn_ts_valid <= s.syn_ts_valid;
      req_weight <= s.weight;
      req_index <= s.index;
      req_syn_parity <= s.syn_parity;
      req_core_valid <= s.core_valid;
      req_core_parity <= s.core_parity;
      req_out_queue_level <= s.level;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // wait until every response is back and the pipe is quiet
   task automatic drain_releases();
      req_valid <= 1'b0;
      while (exp_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      queue_limit = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic syn_step_type entry_step(input logic par,
                                               input logic [WEIGHT_W-1:0] w,
                                               input logic [INDEX_W-1:0] idx,
                                               input logic [LEVEL_W-1:0] lvl);
      syn_step_type s;
      s = '0;
      s.syn_valid = 1'b1;
      s.syn_ts_valid = 1'b1;
      s.syn_parity = par;
      s.weight = w;
      s.index = idx;
      s.level = lvl;
      return s;
   endfunction

   function automatic syn_step_type core_step(input logic cv, input logic cp,
                                              input logic [LEVEL_W-1:0] lvl);
      syn_step_type s;
      s = '0;
      s.core_valid = cv;
      s.core_parity = cp;
      s.level = lvl;
      return s;
   endfunction

   // mostly well-ordered entries with random content, some noise
   function automatic syn_step_type random_step();
      syn_step_type       s;
      int                 pick;
      logic [LIMIT_W-1:0] lvl_max;
      pick = int'($urandom_range(99));
      s.weight = $urandom;
      s.index = INDEX_W'($urandom_range(16'hFFFF));
      s.core_valid = ($urandom_range(99) < 20);
      s.core_parity = ($urandom_range(99) < 70) ? last_parity : ~last_parity;
      if (pick < 8) begin
         s.syn_valid = 1'($urandom_range(1));
         s.syn_ts_valid = 1'($urandom_range(1));
         s.syn_parity = 1'($urandom_range(1));
         s.core_parity = 1'($urandom_range(1));
         s.level = LEVEL_W'($urandom_range(255));
         return s;
      end
      s.syn_valid = (pick < 90);
      s.syn_ts_valid = s.syn_valid;
      // keep parity order unless the store is in sync
      if (last_parity != core_parity_q)
         s.syn_parity = ~core_parity_q;
      else
         s.syn_parity = 1'($urandom_range(1));
      lvl_max = (queue_limit > 255) ? 9'd255 : queue_limit;
      case ($urandom_range(9))
         7, 8:    s.level = LEVEL_W'($urandom_range(lvl_max));
         9:       s.level = LEVEL_W'($urandom_range(255));
         default: s.level = LEVEL_W'($urandom_range(2));
      endcase
      return s;
   endfunction

   // direct pass, store and release, order break, half pairs, limit overflow
   task automatic test_directed_paths();
      syn_step_type s;
      send_idle_pct = 20;
      rsp_stall_pct = 30;
      send_step(entry_step(1'b0, 32'hFFFF_FFFF, 16'hFFFF, 8'd0));
      send_step(entry_step(1'b0, 32'h0, 16'h0, 8'd255));
      send_step(entry_step(1'b1, 32'hA5A5_5A5A, 16'h1234, 8'd0));
      send_step(entry_step(1'b0, 32'h1111_2222, 16'h3333, 8'd0));
      s = entry_step(1'b1, 32'h4444_5555, 16'h6666, 8'd7);
      s.syn_ts_valid = 1'b0;
      send_step(s);
      s = entry_step(1'b1, 32'h7777_8888, 16'h9999, 8'd0);
      s.syn_valid = 1'b0;
      s.core_valid = 1'b1;
      s.core_parity = 1'b1;
      send_step(s);
      send_step(core_step(1'b1, 1'b1, 8'd0));
      send_step(entry_step(1'b1, 32'hDEAD_0001, 16'h8001, 8'd1));
      send_step(entry_step(1'b0, 32'hDEAD_0002, 16'h8002, 8'd63));
      send_step(entry_step(1'b0, 32'hDEAD_0003, 16'h8003, 8'd63));
      send_step(core_step(1'b1, 1'b0, 8'd0));
   endtask

   // queue limit at zero, one and its top value
   task automatic test_limit_extremes();
      drain_releases();
      write_limit(9'd0);
      send_step(entry_step(~core_parity_q, 32'h0F0F_0F0F, 16'h00FF, 8'd0));
      send_step(entry_step(~core_parity_q, 32'hF0F0_F0F0, 16'hFF00, 8'd0));
      send_step(core_step(1'b1, last_parity, 8'd0));
      drain_releases();
      write_limit(9'd511);
      send_step(entry_step(~core_parity_q, 32'h1234_5678, 16'hABCD, 8'd255));
      send_step(entry_step(~core_parity_q, 32'h8765_4321, 16'hDCBA, 8'd255));
      send_step(core_step(1'b1, last_parity, 8'd255));
      send_step(core_step(1'b0, 1'b0, 8'd0));
      drain_releases();
      write_limit(9'd1);
      send_step(entry_step(~core_parity_q, 32'hCAFE_0001, 16'h0101, 8'd0));
      send_step(entry_step(~core_parity_q, 32'hCAFE_0002, 16'h0202, 8'd0));
      send_step(core_step(1'b1, last_parity, 8'd0));
   endtask

   // fill the store to the top while responses are held off, then release all
   task automatic test_store_full_backpressure();
      drain_releases();
      write_limit(9'd511);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      while (held_count > 0) send_step(core_step(1'b1, last_parity, 8'd0));
      req_valid <= 1'b0;
      @(posedge clock);
      hold_len = HOLD_CYCLES;
      @(negedge clock);
      repeat (DEPTH + 1)
         send_step(entry_step(~core_parity_q, $urandom,
                              INDEX_W'($urandom_range(16'hFFFF)), 8'd0));
      send_step(core_step(1'b1, last_parity, 8'd0));
      repeat (DEPTH - 1) send_step(core_step(1'b0, 1'b0, 8'd0));
   endtask

   task automatic test_random(input int count, input int send_pct, input int stall_pct,
                              input logic [LIMIT_W-1:0] limit);
      drain_releases();
      write_limit(limit);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) send_step(random_step());
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_paths();
      test_limit_extremes();
      test_store_full_backpressure();
      test_random(330, 35, 75, 9'd12);
      test_random(330, 75, 35, 9'd511);
      test_random(340, 0, 0, LIMIT_RESET);
      drain_releases();
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
